// ----- rtl/clsw_pkg.sv -----
// shared types and constants for the character lcd shadow write filter
`timescale 1ns / 1ps

package clsw_pkg;

  // screen geometry
  localparam int COLUMNS = 8;
  localparam int ROWS    = 2;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int IDX_W   = $clog2(CELLS);

  // operation codes of an input item
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_GOTO  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_HOME  = 2'd3;

  // configuration register indexes
  localparam logic REG_LINE_ONE = 1'b0;
  localparam logic REG_LINE_TWO = 1'b1;

  // controller bytes
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;

  // shared unit operations
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_CMP = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             wr_en;
    logic             clear;
    logic [IDX_W-1:0] addr;
    logic [7:0]       wdata;
  } shadow_ctl_t;

endpackage

// ----- rtl/char_lcd_shadow_write_filter.sv -----
// top level: sequencer, cursor, configuration and output register
`timescale 1ns / 1ps

// Turns put_char, goto, clear and home items into controller bytes for a
// character display while keeping a shadow of the screen, so an unchanged
// character costs no bus traffic. One item is taken at a time; in_ready is
// low until its last step is done. A put_char that changes a cell steps
// through compare, address add, data and cursor add; a put_char that
// matches the shadow does only the compare and the cursor add; goto, clear
// and home have one step each. A step that loads the output register waits
// on out_ready. The steps are set by the single shared adder / comparator,
// which does one operation per cycle. Clear resets the shadow at once
// through per-cell valid bits, so there is no clearing pass after reset.
module char_lcd_shadow_write_filter
  import clsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] char_code,
  input  logic [2:0] column,
  input  logic       row,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       reg_select,
  output logic [7:0] bus_byte,
  output logic       long_wait,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_ADDR = 3'd2;
  localparam logic [2:0] ST_DATA = 3'd3;
  localparam logic [2:0] ST_STEP = 3'd4;
  localparam logic [2:0] ST_CMD  = 3'd5;

  logic [2:0]       state;
  logic [IDX_W-1:0] cursor;
  logic [6:0]       line_one_base;
  logic [6:0]       line_two_base;
  logic [1:0]       kind_q;
  logic [7:0]       code_q;
  logic [COL_W-1:0] col_q;
  logic             row_q;

  alu_req_t    alu_req;
  logic [7:0]  alu_res;
  shadow_ctl_t shadow_ctl;
  logic [7:0]  shadow_rd;
  logic        out_free;
  logic        out_load;
  logic        addr_row;
  logic [COL_W-1:0] addr_col;
  logic [6:0]  addr_base;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  // a result byte is loaded into the output register this cycle
  assign out_load  = out_free &&
                     (state == ST_ADDR || state == ST_DATA || state == ST_CMD);

  // put_char addresses the cursor cell, goto the given cell
  assign addr_row  = (kind_q == KIND_PUT) ? cursor[IDX_W-1] : row_q;
  assign addr_col  = (kind_q == KIND_PUT) ? cursor[COL_W-1:0] : col_q;
  assign addr_base = addr_row ? line_two_base : line_one_base;

  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = 8'd0;
    alu_req.b  = 8'd0;
    unique case (state)
      ST_LOOK: begin
        alu_req.op = ALU_CMP;
        alu_req.a  = code_q;
        alu_req.b  = shadow_rd;
      end
      ST_ADDR: begin
        alu_req.a = {1'b0, addr_base};
        alu_req.b = 8'(addr_col);
      end
      ST_STEP: begin
        alu_req.a = 8'(cursor);
        alu_req.b = 8'd1;
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  clsw_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  always_comb begin
    shadow_ctl.addr  = cursor;
    shadow_ctl.wdata = code_q;
    shadow_ctl.wr_en = (state == ST_DATA) && out_free;
    shadow_ctl.clear = (state == ST_CMD) && out_free && (kind_q == KIND_CLEAR);
  end

  clsw_shadow u_shadow (
    .clk     (clk),
    .rst     (rst),
    .ctl     (shadow_ctl),
    .rd_data (shadow_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_one_base <= 7'd0;
      line_two_base <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_ONE: line_one_base <= cfg_data;
        REG_LINE_TWO: line_two_base <= cfg_data;
        default:      line_one_base <= line_one_base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            kind_q <= kind;
            code_q <= char_code;
            col_q  <= column;
            row_q  <= row;
            unique case (kind) inside
              KIND_PUT:              state <= ST_LOOK;
              KIND_GOTO:             state <= ST_ADDR;
              KIND_CLEAR, KIND_HOME: state <= ST_CMD;
              default:               state <= ST_IDLE;
            endcase
          end
        end
        ST_LOOK: begin
          // unchanged cell: no bus traffic, just move the cursor
          state <= alu_res[0] ? ST_STEP : ST_ADDR;
        end
        ST_ADDR: begin
          if (out_free) begin
            reg_select <= 1'b0;
            bus_byte   <= CMD_SET_ADDR | {1'b0, alu_res[6:0]};
            long_wait  <= 1'b0;
            last       <= (kind_q == KIND_GOTO);
            if (kind_q == KIND_GOTO) begin
              cursor <= {row_q, col_q};
              state  <= ST_IDLE;
            end else begin
              state <= ST_DATA;
            end
          end
        end
        ST_DATA: begin
          if (out_free) begin
            reg_select <= 1'b1;
            bus_byte   <= code_q;
            long_wait  <= 1'b0;
            last       <= 1'b1;
            state      <= ST_STEP;
          end
        end
        ST_STEP: begin
          cursor <= (alu_res >= 8'(CELLS)) ? '0 : alu_res[IDX_W-1:0];
          state  <= ST_IDLE;
        end
        ST_CMD: begin
          if (out_free) begin
            reg_select <= 1'b0;
            bus_byte   <= (kind_q == KIND_CLEAR) ? CMD_CLEAR : CMD_HOME;
            long_wait  <= 1'b1;
            last       <= 1'b1;
            cursor     <= '0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a data byte always closes its item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && reg_select |-> last)
    else $error("data byte without last");

  // only clear and home commands ask for the long wait
  assert property (@(posedge clk) disable iff (rst)
    out_valid && long_wait |-> !reg_select &&
      (bus_byte == CMD_CLEAR || bus_byte == CMD_HOME))
    else $error("long wait on wrong byte");

  // while the data byte waits, the address command of the same cell is held
  assert property (@(posedge clk) disable iff (rst)
    state == ST_DATA |-> out_valid && !reg_select && !last)
    else $error("data step without pending address command");

  // clear and home return the cursor to the first cell and free the block
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMD) && out_free |=> (cursor == '0) && (state == ST_IDLE))
    else $error("clear or home left cursor or state wrong");
`endif

endmodule

// ----- rtl/clsw_alu.sv -----
// shared add / compare unit used by the sequencer
`timescale 1ns / 1ps

module clsw_alu
  import clsw_pkg::*;
(
  input  alu_req_t   req,
  output logic [7:0] res
);

  always_comb begin
    unique case (req.op)
      ALU_ADD: res = req.a + req.b;
      ALU_CMP: res = (req.a == req.b) ? 8'd1 : 8'd0;
      default: res = 8'd0;
    endcase
  end

endmodule

// ----- rtl/clsw_shadow.sv -----
// shadow copy of the screen, one byte per cell, cleared to spaces by valid bits
`timescale 1ns / 1ps

module clsw_shadow
  import clsw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  shadow_ctl_t ctl,
  output logic [7:0]  rd_data
);

  logic [7:0]       cells [CELLS];
  logic [CELLS-1:0] filled;

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (ctl.clear) begin
      filled <= '0;
    end else if (ctl.wr_en) begin
      filled[ctl.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      cells[ctl.addr] <= ctl.wdata;
    end
  end

  // a cell never written since reset or clear reads as a space
  assign rd_data = filled[ctl.addr] ? cells[ctl.addr] : CHAR_SPACE;

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the character lcd shadow write filter
`timescale 1ns / 1ps

module testbench;
  import clsw_pkg::*;

  localparam logic [7:0] CMD_LONG_MAX = 8'h03;
  localparam int         DRAIN_CYCLES = 12;
  localparam int         LONG_STALL   = 300;
  localparam int         PHASE_OPS    = 130;
  localparam int         NUM_PHASES   = 8;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [2:0] column;
    logic       row;
  } lcd_op_t;

  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       long_wait;
    logic       last;
  } bus_word_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic [1:0] kind       = KIND_PUT;
  logic [7:0] char_code  = '0;
  logic [2:0] column     = '0;
  logic       row        = 1'b0;
  logic       out_ready  = 1'b0;
  logic       cfg_valid  = 1'b0;
  logic       cfg_index  = REG_LINE_ONE;
  logic [6:0] cfg_data   = '0;
  logic       in_ready;
  logic       out_valid;
  logic       reg_select;
  logic [7:0] bus_byte;
  logic       long_wait;
  logic       last;
  logic       cfg_ready;

  char_lcd_shadow_write_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .char_code (char_code),
    .column    (column),
    .row       (row),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .reg_select(reg_select),
    .bus_byte  (bus_byte),
    .long_wait (long_wait),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // screen model
  logic [7:0]       shadow_cells[CELLS];
  logic [IDX_W-1:0] cursor;
  logic [6:0]       row0_base = 7'd0;
  logic [6:0]       row1_base = 7'd64;

  lcd_op_t   ops_pending[$];
  bus_word_t bus_words_due[$];

  int send_idle_pct = 24;
  int recv_idle_pct = 66;
  int stall_request = 0;
  int stall_seen    = 0;
  int stall_left    = 0;
  int ops_queued    = 0;
  int ops_taken     = 0;
  int words_seen    = 0;
  int quiet_puts    = 0;
  int cfg_writes    = 0;
  int fault_count   = 0;
  int kind_count[4] = '{default: 0};

  function automatic void push_word(input logic rs, input logic [7:0] b, input logic fin);
    bus_word_t w;
    w.reg_select = rs;
    w.bus_byte   = b;
    w.long_wait  = !rs && b >= CMD_CLEAR && b <= CMD_LONG_MAX;
    w.last       = fin;
    bus_words_due.push_back(w);
  endfunction

  // set-address command, the 7-bit address wraps
  function automatic logic [7:0] addr_cmd(input logic [2:0] col, input logic r);
    logic [6:0] a;
    a = (r ? row1_base : row0_base) + {4'b0, col};
    return CMD_SET_ADDR | {1'b0, a};
  endfunction

  function automatic void predict_bus_words(input lcd_op_t op);
    logic [IDX_W-1:0] here;
    here = cursor;
    case (op.kind)
      KIND_PUT: begin
        if (op.char_code != shadow_cells[here]) begin
          push_word(1'b0, addr_cmd(here[COL_W-1:0], here[IDX_W-1]), 1'b0);
          push_word(1'b1, op.char_code, 1'b1);
          shadow_cells[here] = op.char_code;
        end else begin
          quiet_puts++;
        end
        // screen size is a power of two, so the cursor wraps by itself
        cursor = here + 1'b1;
      end
      KIND_GOTO: begin
        push_word(1'b0, addr_cmd(op.column, op.row), 1'b1);
        cursor = {op.row, op.column};
      end
      KIND_CLEAR: begin
        push_word(1'b0, CMD_CLEAR, 1'b1);
        foreach (shadow_cells[i]) shadow_cells[i] = CHAR_SPACE;
        cursor = '0;
      end
      default: begin
        push_word(1'b0, CMD_HOME, 1'b1);
        cursor = '0;
      end
    endcase
  endfunction

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch: %s", msg);
  endtask

  // sender
  always @(posedge clk) begin : drive_blk
    lcd_op_t nxt;
    logic    offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      offer = ops_pending.size() > 0 && $urandom_range(99) >= send_idle_pct;
      if (offer) begin
        nxt = ops_pending.pop_front();
        kind      <= nxt.kind;
        char_code <= nxt.char_code;
        column    <= nxt.column;
        row       <= nxt.row;
      end
      in_valid <= offer;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      predict_bus_words({kind, char_code, column, row});
      kind_count[kind]++;
      ops_taken++;
    end
  end

  // receiver, with a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (stall_request != stall_seen) begin
      stall_seen = stall_request;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk) begin : check_blk
    bus_word_t got;
    bus_word_t want;
    if (!rst && out_valid && out_ready) begin
      got = {reg_select, bus_byte, long_wait, last};
      words_seen++;
      if (bus_words_due.size() == 0) begin
        report_fault($sformatf("word %0d not expected: rs %0b byte %02h long %0b last %0b",
                               words_seen, got.reg_select, got.bus_byte, got.long_wait,
                               got.last));
      end else begin
        want = bus_words_due.pop_front();
        if (got !== want)
          report_fault($sformatf({"word %0d: expected rs %0b byte %02h long %0b last %0b,",
                                  " got rs %0b byte %02h long %0b last %0b"},
                                 words_seen, want.reg_select, want.bus_byte, want.long_wait,
                                 want.last, got.reg_select, got.bus_byte, got.long_wait,
                                 got.last));
      end
    end
  end

  task automatic queue_op(input logic [1:0] k, input logic [7:0] c, input logic [2:0] col,
                          input logic r);
    ops_pending.push_back('{kind: k, char_code: c, column: col, row: r});
    ops_queued++;
  endtask

  task automatic settle();
    while (ops_taken != ops_queued || bus_words_due.size() != 0) @(negedge clk);
    // a put that matches the shadow leaves no word behind but may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic idx, input logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_LINE_ONE) row0_base = val;
    else row1_base = val;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // mostly line writes: a goto and a run of puts that often repeat the screen text
  task automatic fill_phase(input int n);
    logic [7:0]       text[CELLS];
    logic [IDX_W-1:0] pos;
    int               added;
    int               run;
    foreach (text[i]) text[i] = $urandom_range(1) ? CHAR_SPACE : 8'($urandom);
    added = 0;
    while (added < n) begin
      if ($urandom_range(99) < 70) begin
        pos = IDX_W'($urandom_range(CELLS - 1));
        queue_op(KIND_GOTO, 8'($urandom), pos[COL_W-1:0], pos[IDX_W-1]);
        run = $urandom_range(1, 9);
        repeat (run) begin
          queue_op(KIND_PUT, ($urandom_range(3) != 0) ? text[pos] : 8'($urandom),
                   3'($urandom), 1'($urandom));
          pos++;
        end
        added += run + 1;
      end else begin
        queue_op(2'($urandom), 8'($urandom), 3'($urandom), 1'($urandom));
        added++;
      end
    end
  endtask

  initial begin : stim_blk
    int         p;
    logic [6:0] b_one;
    logic [6:0] b_two;
    foreach (shadow_cells[i]) shadow_cells[i] = CHAR_SPACE;
    cursor = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: matches, byte extremes, wrap at screen end, all operations
    queue_op(KIND_PUT,   8'h20, 3'd0, 1'b0);
    queue_op(KIND_PUT,   8'hFF, 3'd7, 1'b1);
    queue_op(KIND_PUT,   8'h00, 3'd0, 1'b0);
    queue_op(KIND_PUT,   8'h01, 3'd0, 1'b0);
    queue_op(KIND_GOTO,  8'h00, 3'd7, 1'b1);
    queue_op(KIND_PUT,   8'h80, 3'd0, 1'b0);
    queue_op(KIND_PUT,   8'h20, 3'd0, 1'b0);
    queue_op(KIND_PUT,   8'hFF, 3'd0, 1'b0);
    queue_op(KIND_GOTO,  8'hFF, 3'd0, 1'b0);
    queue_op(KIND_PUT,   8'h55, 3'd5, 1'b1);
    queue_op(KIND_PUT,   8'hAA, 3'd2, 1'b0);
    queue_op(KIND_HOME,  8'hFF, 3'd7, 1'b1);
    queue_op(KIND_PUT,   8'h55, 3'd0, 1'b0);
    queue_op(KIND_CLEAR, 8'hFF, 3'd7, 1'b1);
    queue_op(KIND_PUT,   8'h20, 3'd0, 1'b0);
    queue_op(KIND_PUT,   8'h7F, 3'd0, 1'b0);
    queue_op(KIND_GOTO,  8'hFF, 3'd3, 1'b1);
    queue_op(KIND_HOME,  8'h00, 3'd0, 1'b0);
    queue_op(KIND_PUT,   8'h03, 3'd0, 1'b0);

    for (p = 1; p <= NUM_PHASES; p++) begin
      settle();
      if (p == 4) begin
        send_idle_pct = 66;
        recv_idle_pct = 24;
      end
      if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        1: begin
          b_one = 7'd127;
          b_two = 7'd0;
        end
        2: begin
          b_one = 7'd0;
          b_two = 7'd127;
        end
        default: begin
          b_one = 7'($urandom);
          b_two = 7'($urandom);
        end
      endcase
      write_base(REG_LINE_ONE, b_one);
      write_base(REG_LINE_TWO, b_two);
      if (p == 1) begin
        // address past the top of display ram wraps
        queue_op(KIND_GOTO, 8'h00, 3'd7, 1'b0);
        queue_op(KIND_PUT,  8'h41, 3'd0, 1'b0);
        queue_op(KIND_GOTO, 8'h00, 3'd7, 1'b1);
      end
      fill_phase(PHASE_OPS);
      // hold the receiver while the sender keeps pushing, so the block backs up
      if (p == 7) stall_request++;
    end
    settle();

    $display("ran %0d ops: put %0d (%0d hit the shadow), goto %0d, clear %0d, home %0d",
             ops_taken, kind_count[KIND_PUT], quiet_puts, kind_count[KIND_GOTO],
             kind_count[KIND_CLEAR], kind_count[KIND_HOME]);
    $display("checked %0d bus words across %0d base register writes, %0d mismatches",
             words_seen, cfg_writes, fault_count);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog_blk
    #(5_000_000);
    $display("timeout: %0d of %0d ops taken, %0d bus words outstanding",
             ops_taken, ops_queued, bus_words_due.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/clsw_pkg.sv
rtl/clsw_alu.sv
rtl/clsw_shadow.sv
rtl/char_lcd_shadow_write_filter.sv
dv/testbench.sv
